### rtl/core/slbpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbpt_pkg
// Shared widths, register indexes, reset values and types for the
// smoothed level bin pulse trigger.
// ----------------------------------------------------------------------------
package slbpt_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int NOW_W      = 32;
  localparam int BIN_W      = 8;
  localparam int AMP_W      = 16;
  localparam int LEVEL_W    = 32;
  localparam int HALF_W     = 16;
  localparam int WEIGHT_W   = 17;
  localparam int RANGE_W    = 16;
  localparam int PLEN_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // shared multiplier operands and product
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // scaled numerator |f - low| * bins and divider
  localparam int NUM_W = RANGE_W + BIN_W;
  localparam int DSH_W = NUM_W - 1;
  localparam int CNT_W = 3;

  localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LVL  = 3'd5;

  localparam logic [WEIGHT_W-1:0] RST_WEIGHT     = 17'd6554;
  localparam logic [RANGE_W-1:0]  RST_RANGE_LOW  = 16'd0;
  localparam logic [RANGE_W-1:0]  RST_RANGE_HIGH = 16'd4095;
  localparam logic [BIN_W-1:0]    RST_BIN_COUNT  = 8'd10;
  localparam logic [PLEN_W-1:0]   RST_PULSE_LEN  = 16'd20;
  localparam logic [AMP_W-1:0]    RST_PULSE_LVL  = 16'd32768;

  typedef struct packed {
    logic [WEIGHT_W-1:0] smoothing_weight;
    logic [RANGE_W-1:0]  range_low;
    logic [RANGE_W-1:0]  range_high;
    logic [BIN_W-1:0]    bin_count;
    logic [PLEN_W-1:0]   pulse_length_ms;
    logic [AMP_W-1:0]    pulse_level;
  } cfg_t;

  typedef struct packed {
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_HI,
    S_MUL_LO,
    S_MUL_WS,
    S_SUM,
    S_SCALE,
    S_DIV_PREP,
    S_DIV,
    S_BIN,
    S_FINISH
  } seq_state_t;

endpackage

### rtl/core/slbpt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbpt_if
// Valid/ready channels: sample input, result output and register writes.
// ----------------------------------------------------------------------------
interface slbpt_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample;
  logic [31:0] now_ms;

  modport source (output valid, output sample, output now_ms, input ready);
  modport sink   (input valid, input sample, input now_ms, output ready);
endinterface

interface slbpt_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  bin;
  logic        drive_on;
  logic [15:0] amplitude;
  logic        pulse_started;
  logic        pulse_ended;

  modport source (output valid, output bin, output drive_on, output amplitude,
                  output pulse_started, output pulse_ended, input ready);
  modport sink   (input valid, input bin, input drive_on, input amplitude,
                  input pulse_started, input pulse_ended, output ready);
endinterface

interface slbpt_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [16:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/slbpt_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbpt_cfg_regs
// Configuration register file; each write keeps the register's low bits.
// ----------------------------------------------------------------------------
module slbpt_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  slbpt_cfg_if.sink     cfg_bus,
  output slbpt_pkg::cfg_t cfg
);
  import slbpt_pkg::*;

  cfg_t cfg_r;

  assign cfg_bus.ready = 1'b1;
  assign cfg           = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.smoothing_weight <= RST_WEIGHT;
      cfg_r.range_low        <= RST_RANGE_LOW;
      cfg_r.range_high       <= RST_RANGE_HIGH;
      cfg_r.bin_count        <= RST_BIN_COUNT;
      cfg_r.pulse_length_ms  <= RST_PULSE_LEN;
      cfg_r.pulse_level      <= RST_PULSE_LVL;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        REG_WEIGHT:     cfg_r.smoothing_weight <= cfg_bus.data[WEIGHT_W-1:0];
        REG_RANGE_LOW:  cfg_r.range_low        <= cfg_bus.data[RANGE_W-1:0];
        REG_RANGE_HIGH: cfg_r.range_high       <= cfg_bus.data[RANGE_W-1:0];
        REG_BIN_COUNT:  cfg_r.bin_count        <= cfg_bus.data[BIN_W-1:0];
        REG_PULSE_LEN:  cfg_r.pulse_length_ms  <= cfg_bus.data[PLEN_W-1:0];
        REG_PULSE_LVL:  cfg_r.pulse_level      <= cfg_bus.data[AMP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/slbpt_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbpt_mul
// Shared 17x16 multiplier with a registered product.
// ----------------------------------------------------------------------------
module slbpt_mul (
  input  logic                          clk,
  input  slbpt_pkg::mul_req_t           req,
  output logic [slbpt_pkg::MUL_P_W-1:0] prod_r
);
  import slbpt_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= MUL_P_W'(req.a) * MUL_P_W'(req.b);
  end

endmodule

### rtl/core/slbpt_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slbpt_seq
// Sequencer: smoothing on the shared multiplier, bin scaling, restoring
// division, pulse timing and the output register.
// ----------------------------------------------------------------------------
module slbpt_seq #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  slbpt_in_if.sink                      in_bus,
  slbpt_out_if.source                   out_bus,
  input  slbpt_pkg::cfg_t               cfg,
  output slbpt_pkg::mul_req_t           mul_req,
  input  logic [slbpt_pkg::MUL_P_W-1:0] prod_r
);
  import slbpt_pkg::*;

  seq_state_t state_r, state_nxt;

  logic [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [NOW_W-1:0]       now_r, now_nxt;
  logic [WEIGHT_W-1:0]    w_r, w_nxt;
  logic [WEIGHT_W-1:0]    k_r, k_nxt;
  logic [LEVEL_W-1:0]     acc_r, acc_nxt;
  logic [LEVEL_W-1:0]     level_r, level_nxt;
  logic                   mis_r, mis_nxt;
  logic                   den_zero_r, den_zero_nxt;
  logic [RANGE_W-1:0]     den_mag_r, den_mag_nxt;
  logic [NUM_W-1:0]       rem_r, rem_nxt;
  logic [DSH_W-1:0]       dsh_r, dsh_nxt;
  logic [BIN_W-1:0]       quo_r, quo_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   zero_r, zero_nxt;
  logic                   big_r, big_nxt;
  logic [BIN_W-1:0]       bin_r, bin_nxt;
  logic [BIN_W-1:0]       prev_bin_r, prev_bin_nxt;
  logic                   pulsing_r, pulsing_nxt;
  logic [NOW_W-1:0]       begin_r, begin_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [BIN_W-1:0]       out_bin_r, out_bin_nxt;
  logic                   out_drive_r, out_drive_nxt;
  logic [AMP_W-1:0]       out_amp_r, out_amp_nxt;
  logic                   out_start_r, out_start_nxt;
  logic                   out_end_r, out_end_nxt;

  logic [WEIGHT_W-1:0]    w_eff;
  logic [RANGE_W:0]       diff;
  logic [RANGE_W:0]       den;
  logic [RANGE_W:0]       diff_abs;
  logic [RANGE_W:0]       den_abs;
  logic [NUM_W-1:0]       trial;
  logic                   changed;
  logic                   active;
  logic [NOW_W-1:0]       begin_eff;
  logic [NOW_W-1:0]       end_ms;
  logic                   ended;
  logic                   out_free;

  assign in_bus.ready          = (state_r == S_IDLE);
  assign out_bus.valid         = out_valid_r;
  assign out_bus.bin           = out_bin_r;
  assign out_bus.drive_on      = out_drive_r;
  assign out_bus.amplitude     = out_amp_r;
  assign out_bus.pulse_started = out_start_r;
  assign out_bus.pulse_ended   = out_end_r;

  assign w_eff    = (cfg.smoothing_weight > ONE_Q16) ? ONE_Q16 : cfg.smoothing_weight;
  assign diff     = {1'b0, level_r[LEVEL_W-1:HALF_W]} - {1'b0, cfg.range_low};
  assign den      = {1'b0, cfg.range_high} - {1'b0, cfg.range_low};
  assign diff_abs = diff[RANGE_W] ? (~diff + 1'b1) : diff;
  assign den_abs  = den[RANGE_W] ? (~den + 1'b1) : den;
  assign trial    = {1'b0, dsh_r};

  // pulse bookkeeping for the final step
  assign changed   = (bin_r != prev_bin_r);
  assign active    = changed | pulsing_r;
  assign begin_eff = changed ? now_r : begin_r;
  assign end_ms    = begin_eff + NOW_W'(cfg.pulse_length_ms);
  assign ended     = active && (now_r >= end_ms);
  assign out_free  = !out_valid_r || out_bus.ready;

  always_comb begin
    state_nxt     = state_r;
    sample_nxt    = sample_r;
    now_nxt       = now_r;
    w_nxt         = w_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    level_nxt     = level_r;
    mis_nxt       = mis_r;
    den_zero_nxt  = den_zero_r;
    den_mag_nxt   = den_mag_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    zero_nxt      = zero_r;
    big_nxt       = big_r;
    bin_nxt       = bin_r;
    prev_bin_nxt  = prev_bin_r;
    pulsing_nxt   = pulsing_r;
    begin_nxt     = begin_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_bin_nxt   = out_bin_r;
    out_drive_nxt = out_drive_r;
    out_amp_nxt   = out_amp_r;
    out_start_nxt = out_start_r;
    out_end_nxt   = out_end_r;
    mul_req.a     = k_r;
    mul_req.b     = level_r[LEVEL_W-1:HALF_W];

    case (state_r)
      S_IDLE: begin
        if (in_bus.valid) begin
          sample_nxt = in_bus.sample[SAMPLE_BITS-1:0];
          now_nxt    = in_bus.now_ms;
          w_nxt      = w_eff;
          k_nxt      = ONE_Q16 - w_eff;
          state_nxt  = S_MUL_HI;
        end
      end
      S_MUL_HI: begin
        // (k * old) >> 16 = k * old_hi + (k * old_lo) >> 16
        mul_req.a = k_r;
        mul_req.b = level_r[LEVEL_W-1:HALF_W];
        state_nxt = S_MUL_LO;
      end
      S_MUL_LO: begin
        mul_req.a = k_r;
        mul_req.b = level_r[HALF_W-1:0];
        acc_nxt   = prod_r[LEVEL_W-1:0];
        state_nxt = S_MUL_WS;
      end
      S_MUL_WS: begin
        mul_req.a = w_r;
        mul_req.b = MUL_B_W'(sample_r);
        acc_nxt   = acc_r + LEVEL_W'(prod_r[MUL_P_W-1:HALF_W]);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        level_nxt = acc_r + prod_r[LEVEL_W-1:0];
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        mul_req.a    = MUL_A_W'(diff_abs[RANGE_W-1:0]);
        mul_req.b    = MUL_B_W'(cfg.bin_count);
        mis_nxt      = diff[RANGE_W] ^ den[RANGE_W];
        den_zero_nxt = (den == '0);
        den_mag_nxt  = den_abs[RANGE_W-1:0];
        state_nxt    = S_DIV_PREP;
      end
      S_DIV_PREP: begin
        rem_nxt  = prod_r[NUM_W-1:0];
        dsh_nxt  = {den_mag_r, {(BIN_W-1){1'b0}}};
        quo_nxt  = '0;
        cnt_nxt  = '1;
        // a zero numerator or a sign mismatch truncates to zero or below; a zero range also gives zero
        zero_nxt = (prod_r[NUM_W-1:0] == '0) || den_zero_r || mis_r;
        // quotient of 256 or more clamps to the bin count unless the zero case applies
        big_nxt  = (prod_r[NUM_W-1:0] >= {den_mag_r, {BIN_W{1'b0}}});
        if (zero_nxt || big_nxt) begin
          state_nxt = S_BIN;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_r >= trial) begin
          rem_nxt = rem_r - trial;
          quo_nxt = {quo_r[BIN_W-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_r[BIN_W-2:0], 1'b0};
        end
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_BIN;
        end
      end
      S_BIN: begin
        if (zero_r) begin
          bin_nxt = '0;
        end else if (big_r || (quo_r > cfg.bin_count)) begin
          bin_nxt = cfg.bin_count;
        end else begin
          bin_nxt = quo_r;
        end
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          prev_bin_nxt  = bin_r;
          begin_nxt     = begin_eff;
          pulsing_nxt   = active && !ended;
          out_valid_nxt = 1'b1;
          out_bin_nxt   = bin_r;
          out_drive_nxt = active && !ended;
          out_amp_nxt   = (active && !ended) ? cfg.pulse_level : '0;
          out_start_nxt = changed;
          out_end_nxt   = ended;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      level_r     <= '0;
      prev_bin_r  <= '0;
      pulsing_r   <= 1'b0;
      begin_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      prev_bin_r  <= prev_bin_nxt;
      pulsing_r   <= pulsing_nxt;
      begin_r     <= begin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r    <= sample_nxt;
    now_r       <= now_nxt;
    w_r         <= w_nxt;
    k_r         <= k_nxt;
    acc_r       <= acc_nxt;
    mis_r       <= mis_nxt;
    den_zero_r  <= den_zero_nxt;
    den_mag_r   <= den_mag_nxt;
    rem_r       <= rem_nxt;
    dsh_r       <= dsh_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    zero_r      <= zero_nxt;
    big_r       <= big_nxt;
    bin_r       <= bin_nxt;
    out_bin_r   <= out_bin_nxt;
    out_drive_r <= out_drive_nxt;
    out_amp_r   <= out_amp_nxt;
    out_start_r <= out_start_nxt;
    out_end_r   <= out_end_nxt;
  end

endmodule

### rtl/core/smoothed_level_bin_pulse_trigger_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smoothed_level_bin_pulse_trigger_top
// Exponential smoothing of a sensor level, linear binning and a timed
// vibration pulse on every change of bin.
// ----------------------------------------------------------------------------
//  channel   direction  handshake     payload
//  in_bus    sink       valid/ready   sample[15:0], now_ms[31:0]
//  out_bus   source     valid/ready   bin, drive_on, amplitude, pulse_started,
//                                     pulse_ended
//  cfg_bus   sink       valid/ready   index[2:0], data[16:0]; always ready
//
//  An item goes from accept to result through three passes through the
//  shared multiplier for the smoothing, one for scaling, then up to eight
//  restoring division steps, a bin step and the pulse/output step.
//  Empty, negative or saturated bins skip the division steps.
//  rst_n is synchronous; it clears the level, bin and pulse state.
//  A result held by a stalled out_bus holds the sequencer in its last step.
// ----------------------------------------------------------------------------
module smoothed_level_bin_pulse_trigger_top #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  slbpt_in_if.sink     in_bus,
  slbpt_out_if.source  out_bus,
  slbpt_cfg_if.sink    cfg_bus
);
  import slbpt_pkg::*;

  cfg_t                 cfg;
  mul_req_t             mul_req;
  logic [MUL_P_W-1:0]   prod_r;

  slbpt_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  slbpt_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod_r)
  );

  slbpt_seq #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg     (cfg),
    .mul_req (mul_req),
    .prod_r  (prod_r)
  );

endmodule
